// ===== hdl/mailbox_endpoint_init_handshake_assert.svh =====
// Assertion macros for the mailbox endpoint start-up handshake
// No dependencies; included by the top level only
`ifndef MAILBOX_ENDPOINT_INIT_HANDSHAKE_ASSERT_SVH
`define MAILBOX_ENDPOINT_INIT_HANDSHAKE_ASSERT_SVH

// same-cycle implication, disabled during reset
`define MEIH_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("meih assertion failed");

// next-cycle implication, disabled during reset
`define MEIH_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("meih assertion failed");

`endif

// ===== hdl/meih_pkg.sv =====
// Package for the mailbox endpoint start-up handshake
// Holds widths, codes, message constants and the result type; no dependencies
`timescale 1ns / 1ps

package meih_pkg;

    localparam int WORD_W            = 64;
    localparam int ADDR_W            = 44;
    localparam int SIZE_W            = 45;
    localparam int CFG_IDX_W         = 2;
    localparam int MAX_ENDPOINTS_DEF = 32;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BUFFER_BASE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BUFFER_SIZE = 2'd1;

    localparam logic [SIZE_W-1:0] BUFFER_SIZE_RESET = 45'd65536;

    // endpoints and message types
    localparam logic [7:0] EP_CTRL    = 8'd0;
    localparam logic [7:0] EP_BUF_A   = 8'd1;
    localparam logic [7:0] EP_BUF_B   = 8'd4;
    localparam logic [7:0] TYPE_HELLO = 8'd1;
    localparam logic [7:0] TYPE_PWROK = 8'd7;
    localparam logic [7:0] TYPE_MAP   = 8'd8;

    // outgoing message templates
    localparam logic [WORD_W-1:0] MSG_WAKE        = 64'h0060_0000_0000_0220;
    localparam logic [WORD_W-1:0] MSG_HELLO_REPLY = 64'h0020_0001_0000_0000;
    localparam logic [WORD_W-1:0] MSG_MAP_ACK     = 64'h0080_0000_0000_0000;
    localparam logic [WORD_W-1:0] MAP_SUB_MASK    = 64'h0008_0007_0000_0000;
    localparam logic [WORD_W-1:0] MSG_EP_START    = 64'h0050_0000_0000_0002;
    localparam logic [WORD_W-1:0] MSG_PWROK_REPLY = 64'h00b0_0000_0000_0000;

    typedef enum logic [1:0] {
        ACT_SEND    = 2'd0,
        ACT_RUN_BIT = 2'd1,
        ACT_STATUS  = 2'd2
    } t_action;

    typedef enum logic [2:0] {
        STS_BUSY      = 3'd0,
        STS_DONE      = 3'd1,
        STS_BAD_EP    = 3'd2,
        STS_BAD_TYPE  = 3'd3,
        STS_NO_MEM    = 3'd4,
        STS_BAD_PHASE = 3'd5
    } t_status;

    typedef struct packed {
        t_action             action;
        logic [WORD_W-1:0]   out_word0;
        logic [WORD_W-1:0]   out_word1;
        t_status             status;
        logic                last;
    } t_result;

endpackage

// ===== hdl/meih_if.sv =====
// Channel interfaces for the mailbox endpoint start-up handshake
// Depends on meih_pkg for widths and codes
`timescale 1ns / 1ps

interface meih_in_if;
    import meih_pkg::*;
    logic              valid;
    logic              ready;
    logic              kind;
    logic              cpu_running;
    logic [WORD_W-1:0] msg_word0;
    logic [WORD_W-1:0] msg_word1;
    modport source (output valid, kind, cpu_running, msg_word0, msg_word1, input ready);
    modport sink   (input valid, kind, cpu_running, msg_word0, msg_word1, output ready);
endinterface

interface meih_out_if;
    import meih_pkg::*;
    logic              valid;
    logic              ready;
    t_action           action;
    logic [WORD_W-1:0] out_word0;
    logic [WORD_W-1:0] out_word1;
    t_status           status;
    logic              last;
    modport source (output valid, action, out_word0, out_word1, status, last, input ready);
    modport sink   (input valid, action, out_word0, out_word1, status, last, output ready);
endinterface

interface meih_cfg_if;
    import meih_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [WORD_W-1:0]    data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== hdl/mailbox_endpoint_init_handshake.sv =====
// Host side of a coprocessor mailbox start-up handshake
// A sequencer with one shared 45-bit adder, a registered endpoint list memory
// and a one-entry output register. Channels i_in (start or received message),
// o_out (message to send, run-bit request or status) and i_cfg (buffer_base at
// index 0, buffer_size at index 1; always ready; written while the block idles,
// a rule for the user that the block does not enforce). Every request is taken
// only when the sequencer is idle; o_out is a register, so the next request can
// be taken while the last result still waits. Steps per request:
//   start, hello, power-ok and error results: a decode step to the output register
//   endpoint-map round: decode, a scan over message bits 0 to 31, then the ack,
//     then per collected endpoint a list memory read and a start message
//   buffer request: two passes through the shared adder, then the result
// A stalled receiver holds the sequencer in its current emit step; nothing is
// lost or repeated. Reset clears phase, endpoint count, allocation offset and
// buffer_base and sets buffer_size to 65536; the list memory needs no clearing
// pass, only entries below the count are read.
`timescale 1ns / 1ps
`include "mailbox_endpoint_init_handshake_assert.svh"

module mailbox_endpoint_init_handshake #(
    parameter int MAX_ENDPOINTS = meih_pkg::MAX_ENDPOINTS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    meih_cfg_if.sink    i_cfg,
    meih_in_if.sink     i_in,
    meih_out_if.source  o_out
);
    import meih_pkg::*;

    localparam int CNT_W = $clog2(MAX_ENDPOINTS + 1);
    localparam int IDX_W = (MAX_ENDPOINTS > 1) ? $clog2(MAX_ENDPOINTS) : 1;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_HELLO = 3'd1,
        PH_MAP   = 3'd2,
        PH_PWROK = 3'd3,
        PH_DONE  = 3'd4
    } t_phase;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SCAN,
        ST_ACK,
        ST_START_RD,
        ST_START_EMIT,
        ST_ADD_REQ,
        ST_ADD_ADDR,
        ST_ALLOC
    } t_state;

    t_state              r_state;
    t_phase              r_phase;
    logic [CNT_W-1:0]    r_count;
    logic [CNT_W-1:0]    r_n;
    logic [4:0]          r_bit;
    logic                r_kind;
    logic                r_cpu_running;
    logic [WORD_W-1:0]   r_w0;
    logic [WORD_W-1:0]   r_w1;
    logic [ADDR_W-1:0]   r_base;
    logic [SIZE_W-1:0]   r_size;
    logic [SIZE_W-1:0]   r_offset;
    logic [SIZE_W:0]     r_sum;
    logic [ADDR_W-1:0]   r_addr;
    logic                r_oom;
    logic                r_o_valid;
    t_result             r_o_res;
    logic [7:0]          r_ep_mem [MAX_ENDPOINTS];
    logic [7:0]          r_rd_data;

    logic [7:0]          w_ep;
    logic [7:0]          w_type;
    logic                w_slot;
    logic                w_ld;
    logic                w_accept;
    logic                w_final;
    logic [WORD_W-1:0]   w_ack;
    logic                w_start_last;
    logic                w_mem_we;
    logic                w_scan_end;
    logic [SIZE_W-1:0]   w_add_b;
    logic [SIZE_W:0]     w_sum;

    t_result             n_res;
    t_phase              n_phase;
    logic                n_emit;
    logic                n_scan;
    logic                n_alloc;
    logic                n_clear;

    // ports
    assign i_cfg.ready     = 1'b1;
    assign i_in.ready      = (r_state == ST_IDLE);
    assign o_out.valid     = r_o_valid;
    assign o_out.action    = r_o_res.action;
    assign o_out.out_word0 = r_o_res.out_word0;
    assign o_out.out_word1 = r_o_res.out_word1;
    assign o_out.status    = r_o_res.status;
    assign o_out.last      = r_o_res.last;

    assign w_accept = i_in.valid && (r_state == ST_IDLE);
    assign w_slot   = !r_o_valid || o_out.ready;
    assign w_ep     = r_w1[7:0];
    assign w_type   = r_w0[59:52];

    // map round acknowledge word
    assign w_final = r_w0[51];
    assign w_ack   = MSG_MAP_ACK | (r_w0 & MAP_SUB_MASK)
                   | {{(WORD_W-1){1'b0}}, (r_w0[34:32] == 3'b000)};
    assign w_start_last = ((r_n + CNT_W'(1)) == r_count);

    // endpoint list write during the bit scan
    assign w_mem_we = (r_state == ST_SCAN) && r_w0[r_bit]
                   && (r_count < CNT_W'(MAX_ENDPOINTS));
    assign w_scan_end = (r_state == ST_SCAN) && (r_bit == 5'd31);

    // shared adder: offset + request bytes, then base + offset
    assign w_add_b = (r_state == ST_ADD_REQ) ? {25'd0, r_w0[51:44], 12'd0}
                                             : {1'b0, r_base};
    assign w_sum   = {1'b0, r_offset} + {1'b0, w_add_b};

    // result selection for the current step
    always_comb begin
        n_res   = '{action: ACT_STATUS, out_word0: '0, out_word1: '0,
                    status: STS_BUSY, last: 1'b1};
        n_phase = r_phase;
        n_emit  = 1'b0;
        n_scan  = 1'b0;
        n_alloc = 1'b0;
        n_clear = 1'b0;
        unique case (r_state)
            ST_DECODE: begin
                n_emit = 1'b1;
                if (!r_kind) begin
                    n_clear = 1'b1;
                    n_phase = PH_HELLO;
                    if (r_cpu_running) begin
                        n_res.action    = ACT_SEND;
                        n_res.out_word0 = MSG_WAKE;
                    end else begin
                        n_res.action = ACT_RUN_BIT;
                    end
                end else begin
                    unique case (r_phase)
                        PH_HELLO: begin
                            priority if (w_ep != EP_CTRL) begin
                                n_res.status = STS_BAD_EP;
                                n_phase      = PH_IDLE;
                            end else if (w_type != TYPE_HELLO) begin
                                n_res.status = STS_BAD_TYPE;
                                n_phase      = PH_IDLE;
                            end else begin
                                n_res.action    = ACT_SEND;
                                n_res.out_word0 = MSG_HELLO_REPLY | {32'd0, r_w0[31:0]};
                                n_phase         = PH_MAP;
                            end
                        end
                        PH_MAP: begin
                            priority if (w_ep != EP_CTRL) begin
                                n_res.status = STS_BAD_EP;
                                n_phase      = PH_IDLE;
                            end else if (w_type != TYPE_MAP) begin
                                n_res.status = STS_BAD_TYPE;
                                n_phase      = PH_IDLE;
                            end else begin
                                n_emit = 1'b0;
                                n_scan = 1'b1;
                            end
                        end
                        PH_PWROK: begin
                            priority if (w_ep == EP_BUF_A || w_ep == EP_BUF_B) begin
                                n_emit  = 1'b0;
                                n_alloc = 1'b1;
                            end else if (w_ep != EP_CTRL) begin
                                n_res.status = STS_BAD_EP;
                                n_phase      = PH_IDLE;
                            end else if (w_type != TYPE_PWROK) begin
                                n_res.status = STS_BAD_TYPE;
                                n_phase      = PH_IDLE;
                            end else begin
                                n_res.action    = ACT_SEND;
                                n_res.out_word0 = MSG_PWROK_REPLY | {32'd0, r_w0[31:0]};
                                n_res.status    = STS_DONE;
                                n_phase         = PH_DONE;
                            end
                        end
                        default: begin
                            n_res.status = STS_BAD_PHASE;
                            n_phase      = PH_IDLE;
                        end
                    endcase
                end
            end
            ST_ACK: begin
                n_emit          = 1'b1;
                n_res.action    = ACT_SEND;
                n_res.out_word0 = w_ack;
                n_res.last      = !w_final || (r_count == '0);
                if (w_final) begin
                    n_phase = PH_PWROK;
                end
            end
            ST_START_EMIT: begin
                n_emit          = 1'b1;
                n_res.action    = ACT_SEND;
                n_res.out_word0 = MSG_EP_START | {24'd0, r_rd_data, 32'd0};
                n_res.last      = w_start_last;
            end
            ST_ALLOC: begin
                n_emit = 1'b1;
                if (r_oom) begin
                    n_res.status = STS_NO_MEM;
                    n_phase      = PH_IDLE;
                end else begin
                    n_res.action    = ACT_SEND;
                    n_res.out_word0 = {r_w0[WORD_W-1:ADDR_W], r_addr};
                    n_res.out_word1 = r_w1;
                end
            end
            default: ;
        endcase
    end

    assign w_ld = n_emit && w_slot;

    // endpoint list memory, registered read
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_ep_mem[r_count[IDX_W-1:0]] <= {r_w0[34:32], r_bit};
        end
        r_rd_data <= r_ep_mem[r_n[IDX_W-1:0]];
    end

    // sequencer, configuration and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_phase   <= PH_IDLE;
            r_count   <= '0;
            r_n       <= '0;
            r_bit     <= '0;
            r_offset  <= '0;
            r_base    <= '0;
            r_size    <= BUFFER_SIZE_RESET;
            r_o_valid <= 1'b0;
        end else begin
            // configuration writes
            if (i_cfg.valid) begin
                unique case (i_cfg.index)
                    REG_BUFFER_BASE: r_base <= i_cfg.data[ADDR_W-1:0];
                    REG_BUFFER_SIZE: r_size <= i_cfg.data[SIZE_W-1:0];
                    default: ;
                endcase
            end

            // output register
            if (w_ld) begin
                r_o_res   <= n_res;
                r_o_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_o_valid <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_kind        <= i_in.kind;
                        r_cpu_running <= i_in.cpu_running;
                        r_w0          <= i_in.msg_word0;
                        r_w1          <= i_in.msg_word1;
                        r_state       <= ST_DECODE;
                    end
                end
                ST_DECODE: begin
                    priority if (n_scan) begin
                        r_bit   <= '0;
                        r_state <= ST_SCAN;
                    end else if (n_alloc) begin
                        r_state <= ST_ADD_REQ;
                    end else if (w_ld) begin
                        r_phase <= n_phase;
                        if (n_clear) begin
                            r_count <= '0;
                        end
                        r_state <= ST_IDLE;
                    end
                end
                ST_SCAN: begin
                    if (w_mem_we) begin
                        r_count <= r_count + CNT_W'(1);
                    end
                    if (r_bit == 5'd31) begin
                        r_state <= ST_ACK;
                    end else begin
                        r_bit <= r_bit + 5'd1;
                    end
                end
                ST_ACK: begin
                    if (w_ld) begin
                        r_phase <= n_phase;
                        r_n     <= '0;
                        if (w_final && (r_count != '0)) begin
                            r_state <= ST_START_RD;
                        end else begin
                            r_state <= ST_IDLE;
                        end
                    end
                end
                ST_START_RD: begin
                    r_state <= ST_START_EMIT;
                end
                ST_START_EMIT: begin
                    if (w_ld) begin
                        if (w_start_last) begin
                            r_state <= ST_IDLE;
                        end else begin
                            r_n     <= r_n + CNT_W'(1);
                            r_state <= ST_START_RD;
                        end
                    end
                end
                ST_ADD_REQ: begin
                    r_sum   <= w_sum;
                    r_state <= ST_ADD_ADDR;
                end
                ST_ADD_ADDR: begin
                    r_addr  <= w_sum[ADDR_W-1:0];
                    r_oom   <= (r_sum > {1'b0, r_size});
                    r_state <= ST_ALLOC;
                end
                ST_ALLOC: begin
                    if (w_ld) begin
                        r_phase <= n_phase;
                        if (!r_oom) begin
                            r_offset <= r_sum[SIZE_W-1:0];
                        end
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // checks on the sequencer
    `MEIH_ASSERT_NEXT(a_accept_decodes, i_clk, i_rst_n, w_accept, r_state == ST_DECODE)
    `MEIH_ASSERT_NOW(a_count_bounded, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(MAX_ENDPOINTS))
    `MEIH_ASSERT_NOW(a_start_in_list, i_clk, i_rst_n, r_state == ST_START_EMIT, r_n < r_count)
    `MEIH_ASSERT_NEXT(a_scan_ends_in_ack, i_clk, i_rst_n, w_scan_end, r_state == ST_ACK)

endmodule
